// ===== src/cluster_run_list_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// cluster run list decoder assertion macros
// shared property wrappers for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef CLUSTER_RUN_LIST_DECODER_CORE_DEFINES_SVH
`define CLUSTER_RUN_LIST_DECODER_CORE_DEFINES_SVH

// implication that must hold at every edge out of reset
`define CRLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen
`define CRLD_NEVER(label, cond, msg) \
    `CRLD_ASSERT(label, !(cond), msg)

`endif

// ===== src/crld_pkg.sv =====
// ----------------------------------------------------------------------------
// crld_pkg
// types shared by the cluster run list decoder modules
// ----------------------------------------------------------------------------
package crld_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2
    } crld_phase_t;

    localparam int unsigned ClusterW = 64;
    localparam int unsigned StartW   = 63;

    typedef struct packed {
        logic [StartW-1:0]   run_start;
        logic [ClusterW-1:0] run_clusters;
        logic                run_valid;
        logic                list_done;
    } crld_result_t;

endpackage

// ===== src/crld_decode.sv =====
// ----------------------------------------------------------------------------
// crld_decode
// run list byte decoder: phase, field counters, accumulators and the start
// cluster adder; produces at most one result per accepted byte
// ----------------------------------------------------------------------------
module crld_decode
    import crld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   data_byte,
    input  logic         list_start,
    input  logic         list_final,
    output crld_result_t res,
    output logic         res_en
);

    crld_phase_t         phase_reg, phase_next, eff_phase;
    logic [3:0]          len_left_reg, len_left_next, len_left_dec;
    logic [3:0]          off_left_reg, off_left_next, off_left_dec;
    logic [3:0]          pos_reg, pos_next, pos_inc;
    logic [ClusterW-1:0] len_acc_reg, len_acc_next, len_merged;
    logic [ClusterW-1:0] delta_acc_reg, delta_acc_next, delta_merged, delta_ext;
    logic [ClusterW-1:0] prev_reg, prev_next, eff_prev;
    logic [ClusterW-1:0] run_delta, run_count, cur;
    logic                stopped_reg, stopped_next, eff_stopped;
    logic                hdr_end, run_done, finish, sign_fill;

    // shared decode of the current byte against the running state
    always_comb
    begin
        eff_phase    = list_start ? PH_HEADER : phase_reg;
        eff_stopped  = list_start ? 1'b0 : stopped_reg;
        eff_prev     = list_start ? '0 : prev_reg;
        len_left_dec = len_left_reg - 4'd1;
        off_left_dec = off_left_reg - 4'd1;
        pos_inc      = pos_reg + 4'd1;
        hdr_end      = (data_byte[3:0] == 4'd0) || list_final;

        // byte lanes past the eighth are dropped
        len_merged   = len_acc_reg;
        delta_merged = delta_acc_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (!pos_reg[3] && (pos_reg[2:0] == 3'(i)))
            begin
                len_merged[i*8 +: 8]   = data_byte;
                delta_merged[i*8 +: 8] = data_byte;
            end
        end

        // short negative delta: fill the upper lanes with ones
        sign_fill = data_byte[7] && !pos_inc[3] && (pos_inc != 4'd0);
        delta_ext = delta_merged;
        for (int i = 0; i < 8; i++)
        begin
            if (sign_fill && (4'(i) >= pos_inc))
                delta_ext[i*8 +: 8] = 8'hFF;
        end

        run_done = ((eff_phase == PH_LENGTH) && (len_left_dec == 4'd0)
                    && (off_left_reg == 4'd0))
                || ((eff_phase == PH_OFFSET) && (off_left_dec == 4'd0));
        run_delta = (eff_phase == PH_OFFSET) ? delta_ext : delta_acc_reg;
        run_count = (eff_phase == PH_LENGTH) ? len_merged : len_acc_reg;
        cur       = eff_prev + run_delta;

        case (eff_phase)
            PH_HEADER: finish = !eff_stopped && hdr_end;
            PH_LENGTH: finish = !eff_stopped && !run_done && list_final;
            PH_OFFSET: finish = !eff_stopped && !run_done && list_final;
            default:   finish = 1'b0;
        endcase
    end

    // phase transitions
    always_comb
    begin
        phase_next = eff_phase;
        if (!eff_stopped)
        begin
            case (eff_phase)
                PH_HEADER: phase_next = hdr_end ? PH_HEADER : PH_LENGTH;
                PH_LENGTH:
                begin
                    if (run_done || finish)
                        phase_next = PH_HEADER;
                    else if (len_left_dec == 4'd0)
                        phase_next = PH_OFFSET;
                    else
                        phase_next = PH_LENGTH;
                end
                PH_OFFSET: phase_next = (run_done || finish) ? PH_HEADER : PH_OFFSET;
                default:   phase_next = PH_HEADER;
            endcase
        end
    end

    // counters, accumulators and result
    always_comb
    begin
        stopped_next   = eff_stopped;
        prev_next      = eff_prev;
        len_left_next  = len_left_reg;
        off_left_next  = off_left_reg;
        pos_next       = pos_reg;
        len_acc_next   = len_acc_reg;
        delta_acc_next = delta_acc_reg;
        res            = '0;
        res_en         = 1'b0;

        if (!eff_stopped)
        begin
            case (eff_phase)
                PH_HEADER:
                begin
                    if (!hdr_end)
                    begin
                        len_left_next  = data_byte[3:0];
                        off_left_next  = data_byte[7:4];
                        pos_next       = 4'd0;
                        len_acc_next   = '0;
                        delta_acc_next = '0;
                    end
                end
                PH_LENGTH:
                begin
                    len_acc_next  = len_merged;
                    len_left_next = len_left_dec;
                    pos_next      = ((len_left_dec == 4'd0) && (off_left_reg != 4'd0))
                                    ? 4'd0 : pos_inc;
                end
                PH_OFFSET:
                begin
                    delta_acc_next = delta_merged;
                    off_left_next  = off_left_dec;
                    pos_next       = pos_inc;
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase

            if (run_done)
            begin
                prev_next    = cur;
                stopped_next = list_final;
                if (!cur[ClusterW-1])
                begin
                    res.run_start    = cur[StartW-1:0];
                    res.run_clusters = run_count;
                    res.run_valid    = 1'b1;
                    res.list_done    = list_final;
                    res_en           = 1'b1;
                end
                else if (list_final)
                begin
                    res.list_done = 1'b1;
                    res_en        = 1'b1;
                end
            end

            if (finish)
            begin
                stopped_next  = 1'b1;
                res.list_done = 1'b1;
                res_en        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            len_left_reg  <= '0;
            off_left_reg  <= '0;
            pos_reg       <= '0;
            len_acc_reg   <= '0;
            delta_acc_reg <= '0;
            prev_reg      <= '0;
            stopped_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            off_left_reg  <= off_left_next;
            pos_reg       <= pos_next;
            len_acc_reg   <= len_acc_next;
            delta_acc_reg <= delta_acc_next;
            prev_reg      <= prev_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

// ===== src/crld_out_buf.sv =====
// ----------------------------------------------------------------------------
// crld_out_buf
// two-entry result buffer: output register plus skid entry
// ----------------------------------------------------------------------------
module crld_out_buf
    import crld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  crld_result_t push_data,
    input  logic         pop_ready,
    output logic         head_valid,
    output crld_result_t head_data,
    output logic         full
);

    logic         head_valid_reg, head_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    crld_result_t head_reg, head_next;
    crld_result_t skid_reg, skid_next;
    logic         pop;

    always_comb
    begin
        pop             = head_valid_reg && pop_ready;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;

        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                head_next       = push_data;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                // skid is free here, since ready follows it
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign head_valid = head_valid_reg;
    assign head_data  = head_reg;
    assign full       = skid_valid_reg;

endmodule

// ===== src/cluster_run_list_decoder_core.sv =====
// ----------------------------------------------------------------------------
// cluster_run_list_decoder_core
// streaming run list decoder: one byte in, at most one decoded run out
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | data_byte, list_start, list_final
//  output  | out_valid / out_ready| run_start, run_clusters, run_valid,
//          |                      | list_done
//
//  one byte per cycle while in_ready is high; the 64-bit start cluster adder
//  sits between the decode state and the result register. results go through a
//  two-entry buffer; in_ready drops only when both entries hold a result not
//  yet taken.
//  rst_n clears the decode state to an empty list and empties the buffer.
// ----------------------------------------------------------------------------
module cluster_run_list_decoder_core
    import crld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        list_start,
    input  logic        list_final,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [62:0] run_start,
    output logic [63:0] run_clusters,
    output logic        run_valid,
    output logic        list_done
);

    logic         take;
    logic         res_en;
    logic         buf_full;
    crld_result_t res;
    crld_result_t head;

    assign in_ready = !buf_full;
    assign take     = in_valid && in_ready;

    crld_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .list_start (list_start),
        .list_final (list_final),
        .res        (res),
        .res_en     (res_en)
    );

    crld_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take && res_en),
        .push_data  (res),
        .pop_ready  (out_ready),
        .head_valid (out_valid),
        .head_data  (head),
        .full       (buf_full)
    );

    assign run_start    = head.run_start;
    assign run_clusters = head.run_clusters;
    assign run_valid    = head.run_valid;
    assign list_done    = head.list_done;

endmodule

// ===== src/crld_checker.sv =====
// ----------------------------------------------------------------------------
// crld_checker
// port-level checks on the run list decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "cluster_run_list_decoder_core_defines.svh"

module crld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        list_start,
    input logic        list_final,
    input logic        out_valid,
    input logic        out_ready,
    input logic [62:0] run_start,
    input logic [63:0] run_clusters,
    input logic        run_valid,
    input logic        list_done
);

    logic [128:0] out_payload;
    logic         lone_byte;

    assign out_payload = {run_start, run_clusters, run_valid, list_done};
    assign lone_byte   = in_valid && in_ready && list_start && list_final && !out_valid;

    // a stalled result holds its payload
    `CRLD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload), "result changed while stalled")

    // every result carries a run or a list end
    `CRLD_NEVER(a_empty_result, out_valid && !run_valid && !list_done, "result with no run")

    // a result without a run carries zero fields
    `CRLD_ASSERT(a_zero_fields, out_valid && !run_valid |-> out_payload[128:2] == '0, "nonzero fields")

    // input back-pressure only with a result waiting
    `CRLD_NEVER(a_ready_low, !in_ready && !out_valid, "input stalled with no result held")

    // a lone header byte ends the list at once
    `CRLD_ASSERT(a_lone_header, lone_byte |=> out_valid && list_done && !run_valid, "list did not end")

endmodule

bind cluster_run_list_decoder_core crld_checker u_crld_checker (.*);
